[hw/rtl/touch_pad_gesture_decoder_core_macros.svh]
// ----------------------------------------------------------------------------
// touch pad gesture decoder assertion macros
// shared concurrent assertion forms, reset disables checking
// ----------------------------------------------------------------------------
`ifndef TOUCH_PAD_GESTURE_DECODER_CORE_MACROS_SVH
`define TOUCH_PAD_GESTURE_DECODER_CORE_MACROS_SVH

// consequent in the same cycle
`define TPG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent in the next cycle
`define TPG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/tpg_pkg.sv]
// ----------------------------------------------------------------------------
// tpg_pkg
// shared types and constants of the touch pad gesture decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tpg_pkg;

  localparam int NUM_PADS = 4;
  localparam int LEVEL_W  = 4;
  localparam int PAD_W    = 2;
  localparam int POS_W    = 16;
  localparam int CNT_W    = 8;
  localparam int DEB_W    = 4;

  localparam logic [LEVEL_W-1:0] PAD_MASK =
    (NUM_PADS >= LEVEL_W) ? {LEVEL_W{1'b1}} : LEVEL_W'((1 << NUM_PADS) - 1);

  localparam logic [DEB_W-1:0] DEBOUNCE_RST = DEB_W'(2);
  localparam logic [CNT_W-1:0] LONG_RST     = CNT_W'(100);
  localparam logic [CNT_W-1:0] WINDOW_RST   = CNT_W'(20);
  localparam logic [POS_W-1:0] POS_RST      = POS_W'(1000);

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CW    = 3;

  typedef enum logic [2:0] {
    GEST_LONG   = 3'd0,
    GEST_DOUBLE = 3'd1,
    GEST_SINGLE = 3'd2,
    GEST_UP     = 3'd3,
    GEST_DOWN   = 3'd4
  } gesture_t;

  typedef enum logic [1:0] {
    CFG_DEBOUNCE       = 2'd0,
    CFG_LONG_PRESS     = 2'd1,
    CFG_DOUBLE_WINDOW  = 2'd2,
    CFG_POSITION_START = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [DEB_W-1:0] debounce_ticks;
    logic [CNT_W-1:0] long_press_ticks;
    logic [CNT_W-1:0] double_window_ticks;
    logic             pos_load;
    logic [POS_W-1:0] pos_value;
  } cfg_t;

  typedef struct packed {
    logic [PAD_W-1:0] pad_index;
    gesture_t         gesture;
    logic [POS_W-1:0] position;
    logic             hold_lamp;
    logic             double_lamp;
    logic             last_event;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/touch_pad_gesture_decoder_core.sv]
// ----------------------------------------------------------------------------
// touch_pad_gesture_decoder_core
// decodes long press, double click, single click and slide gestures from
// one tick of touch pad levels per input transaction
//
// channel  direction  ports
// in       input      in_valid, in_ready, in_pad_levels
// out      output     out_valid, out_ready, out_pad_index .. out_last_event
// cfg      input      cfg_valid, cfg_ready, cfg_index, cfg_data
//
// one tick is decoded in the cycle it is accepted; a tick may emit 0 to 2 results
// results leave through a 4 entry queue at one per cycle while out_ready is high
// in_ready drops while fewer than two queue entries are free
// cfg_ready is always high; synchronous active low reset, no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "touch_pad_gesture_decoder_core_macros.svh"

module touch_pad_gesture_decoder_core
  import tpg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [LEVEL_W-1:0] in_pad_levels,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [PAD_W-1:0]        out_pad_index,
  output logic [2:0]              out_gesture,
  output logic [POS_W-1:0]        out_position,
  output logic                    out_hold_lamp,
  output logic                    out_double_lamp,
  output logic                    out_last_event,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [POS_W-1:0]   cfg_data
);

  cfg_t       cfg;
  logic [1:0] res_cnt;
  result_t    res0;
  result_t    res1;
  result_t    head;
  logic       accept;
  logic       room2;

  assign in_ready = room2;
  assign accept   = in_valid && in_ready;

  tpg_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tpg_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_vld   (accept),
    .pad_levels (in_pad_levels),
    .cfg        (cfg),
    .res_cnt    (res_cnt),
    .res0       (res0),
    .res1       (res1)
  );

  tpg_result_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (accept ? res_cnt : 2'd0),
    .push0     (res0),
    .push1     (res1),
    .pop       (out_valid && out_ready),
    .head      (head),
    .not_empty (out_valid),
    .room2     (room2)
  );

  assign out_pad_index   = head.pad_index;
  assign out_gesture     = head.gesture;
  assign out_position    = head.position;
  assign out_hold_lamp   = head.hold_lamp;
  assign out_double_lamp = head.double_lamp;
  assign out_last_event  = head.last_event;

  // a result that is not the last of its tick is always followed by another
  `TPG_ASSERT_NEXT(a_pair_follows, out_valid && !out_last_event, out_valid, "second result missing")

  // only a slide up opens a pair, and the slide down after it steps back
  `TPG_ASSERT_SAME(a_pair_is_up, out_valid && !out_last_event, out_gesture == GEST_UP, "pair not opened by slide up")
  `TPG_ASSERT_NEXT(a_pair_down, out_valid && out_ready && !out_last_event, out_gesture == GEST_DOWN && out_position == $past(out_position) - 16'd1 && out_last_event, "slide pair mismatch")

endmodule

`default_nettype wire

[hw/rtl/tpg_cfg_regs.sv]
// ----------------------------------------------------------------------------
// tpg_cfg_regs
// configuration registers, position start write raises a load strobe
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpg_cfg_regs
  import tpg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [POS_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  logic [DEB_W-1:0] debounce_r;
  logic [CNT_W-1:0] long_r;
  logic [CNT_W-1:0] window_r;
  logic             wr;
  cfg_idx_t         idx;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;
  assign idx       = cfg_idx_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RST;
      long_r     <= LONG_RST;
      window_r   <= WINDOW_RST;
    end else if (wr) begin
      case (idx)
        CFG_DEBOUNCE:      debounce_r <= cfg_data[DEB_W-1:0];
        CFG_LONG_PRESS:    long_r     <= cfg_data[CNT_W-1:0];
        CFG_DOUBLE_WINDOW: window_r   <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.debounce_ticks      = debounce_r;
    cfg.long_press_ticks    = long_r;
    cfg.double_window_ticks = window_r;
    cfg.pos_load            = wr && (idx == CFG_POSITION_START);
    cfg.pos_value           = cfg_data;
  end

endmodule

`default_nettype wire

[hw/rtl/tpg_decode.sv]
// ----------------------------------------------------------------------------
// tpg_decode
// gesture state machine, one tick per transaction, up to two results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpg_decode
  import tpg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               item_vld,
  input  wire logic [LEVEL_W-1:0] pad_levels,
  input  wire cfg_t               cfg,
  output logic [1:0]              res_cnt,
  output result_t                 res0,
  output result_t                 res1
);

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_DEBOUNCE = 3'd1,
    PH_HOLD     = 3'd2,
    PH_WINDOW   = 3'd3,
    PH_WAIT     = 3'd4
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [PAD_W-1:0] active_pad_r, active_pad_nxt;
  logic [CNT_W-1:0] hold_cnt_r, hold_cnt_nxt;
  logic [CNT_W-1:0] win_cnt_r, win_cnt_nxt;
  logic             slide_seen_r, slide_seen_nxt;
  logic [POS_W-1:0] position_r, position_nxt;
  logic             hold_lamp_r, hold_lamp_nxt;
  logic             dbl_lamp_r, dbl_lamp_nxt;

  logic [LEVEL_W-1:0] levels;
  logic               own;
  logic               up;
  logic               down;
  logic [PAD_W:0]     up_idx;
  logic [PAD_W-1:0]   first_pad;

  function automatic result_t mk_res(input logic [PAD_W-1:0] pad, input gesture_t g,
                                     input logic [POS_W-1:0] pos, input logic hl,
                                     input logic dl, input logic last);
    result_t r;
    r.pad_index   = pad;
    r.gesture     = g;
    r.position    = pos;
    r.hold_lamp   = hl;
    r.double_lamp = dl;
    r.last_event  = last;
    return r;
  endfunction

  assign levels = pad_levels & PAD_MASK;
  assign own    = levels[active_pad_r];
  assign up_idx = {1'b0, active_pad_r} + (PAD_W+1)'(1);
  assign up     = (int'(up_idx) < NUM_PADS) && (int'(up_idx) < LEVEL_W)
                  && levels[up_idx[PAD_W-1:0]];
  assign down   = (active_pad_r != '0) && levels[active_pad_r - PAD_W'(1)];

  // lowest touched pad
  always_comb begin
    first_pad = '0;
    for (int i = LEVEL_W - 1; i >= 0; i--) begin
      if (levels[i]) begin
        first_pad = PAD_W'(i);
      end
    end
  end

  always_comb begin
    logic [CNT_W-1:0] hold_inc;
    logic [CNT_W-1:0] win_inc;
    logic [POS_W-1:0] pos_up;
    logic [POS_W-1:0] pos_dn;
    hold_inc       = hold_cnt_r + CNT_W'(1);
    win_inc        = win_cnt_r + CNT_W'(1);
    pos_up         = position_r + POS_W'(1);
    pos_dn         = position_r - POS_W'(1);
    phase_nxt      = phase_r;
    active_pad_nxt = active_pad_r;
    hold_cnt_nxt   = hold_cnt_r;
    win_cnt_nxt    = win_cnt_r;
    slide_seen_nxt = slide_seen_r;
    position_nxt   = position_r;
    hold_lamp_nxt  = hold_lamp_r;
    dbl_lamp_nxt   = dbl_lamp_r;
    res_cnt        = 2'd0;
    res0           = '0;
    res1           = '0;
    case (phase_r)
      PH_DEBOUNCE: begin
        if (!own) begin
          phase_nxt = PH_IDLE;
        end else begin
          hold_cnt_nxt = hold_inc;
          if (hold_inc >= {{(CNT_W-DEB_W){1'b0}}, cfg.debounce_ticks}) begin
            hold_cnt_nxt = '0;
            phase_nxt    = PH_HOLD;
          end
        end
      end
      PH_HOLD: begin
        if (own) begin
          hold_cnt_nxt = hold_inc;
          if (hold_inc >= cfg.long_press_ticks) begin
            hold_lamp_nxt = 1'b1;
            res_cnt       = 2'd1;
            res0 = mk_res(active_pad_r, GEST_LONG, position_r, 1'b1, dbl_lamp_r, 1'b1);
            phase_nxt     = PH_WAIT;
          end
        end else if (up && down) begin
          slide_seen_nxt = 1'b1;
          res_cnt        = 2'd2;
          res0 = mk_res(active_pad_r, GEST_UP, pos_up, hold_lamp_r, dbl_lamp_r, 1'b0);
          res1 = mk_res(active_pad_r, GEST_DOWN, position_r, hold_lamp_r, dbl_lamp_r, 1'b1);
          phase_nxt      = PH_IDLE;
        end else if (up) begin
          slide_seen_nxt = 1'b1;
          position_nxt   = pos_up;
          res_cnt        = 2'd1;
          res0 = mk_res(active_pad_r, GEST_UP, pos_up, hold_lamp_r, dbl_lamp_r, 1'b1);
          phase_nxt      = PH_IDLE;
        end else if (down) begin
          slide_seen_nxt = 1'b1;
          position_nxt   = pos_dn;
          res_cnt        = 2'd1;
          res0 = mk_res(active_pad_r, GEST_DOWN, pos_dn, hold_lamp_r, dbl_lamp_r, 1'b1);
          phase_nxt      = PH_IDLE;
        end else begin
          win_cnt_nxt = '0;
          phase_nxt   = PH_WINDOW;
        end
      end
      PH_WINDOW: begin
        if (own) begin
          dbl_lamp_nxt = 1'b1;
          res_cnt      = 2'd1;
          res0 = mk_res(active_pad_r, GEST_DOUBLE, position_r, hold_lamp_r, 1'b1, 1'b1);
          phase_nxt    = PH_WAIT;
        end else begin
          win_cnt_nxt = win_inc;
          if (win_inc >= cfg.double_window_ticks) begin
            if (slide_seen_r) begin
              slide_seen_nxt = 1'b0;
            end else begin
              hold_lamp_nxt = 1'b0;
              dbl_lamp_nxt  = 1'b0;
              res_cnt       = 2'd1;
              res0 = mk_res(active_pad_r, GEST_SINGLE, position_r, 1'b0, 1'b0, 1'b1);
            end
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_WAIT: begin
        if (!own) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (levels != '0) begin
          active_pad_nxt = first_pad;
          if (cfg.debounce_ticks <= DEB_W'(1)) begin
            hold_cnt_nxt = '0;
            phase_nxt    = PH_HOLD;
          end else begin
            hold_cnt_nxt = CNT_W'(1);
            phase_nxt    = PH_DEBOUNCE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      active_pad_r <= '0;
      hold_cnt_r   <= '0;
      win_cnt_r    <= '0;
      slide_seen_r <= 1'b0;
      position_r   <= POS_RST;
      hold_lamp_r  <= 1'b0;
      dbl_lamp_r   <= 1'b0;
    end else begin
      if (cfg.pos_load) begin
        position_r <= cfg.pos_value;
      end else if (item_vld) begin
        position_r <= position_nxt;
      end
      if (item_vld) begin
        phase_r      <= phase_nxt;
        active_pad_r <= active_pad_nxt;
        hold_cnt_r   <= hold_cnt_nxt;
        win_cnt_r    <= win_cnt_nxt;
        slide_seen_r <= slide_seen_nxt;
        hold_lamp_r  <= hold_lamp_nxt;
        dbl_lamp_r   <= dbl_lamp_nxt;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tpg_result_queue.sv]
// ----------------------------------------------------------------------------
// tpg_result_queue
// four entry result queue, takes up to two results and gives one per cycle while pop is high
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpg_result_queue
  import tpg_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic [1:0] push_cnt,
  input  wire result_t push0,
  input  wire result_t push1,
  input  wire logic    pop,
  output result_t      head,
  output logic         not_empty,
  output logic         room2
);

  result_t          mem [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r;
  logic [Q_AW-1:0]  rd_ptr_r;
  logic [Q_CW-1:0]  count_r;
  logic [Q_AW-1:0]  wr_ptr1;

  assign wr_ptr1   = wr_ptr_r + Q_AW'(1);
  assign head      = mem[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign room2     = (count_r <= Q_CW'(Q_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + Q_AW'(push_cnt);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
      count_r <= count_r + {1'b0, push_cnt} - {{(Q_CW-1){1'b0}}, pop};
    end
  end

endmodule

`default_nettype wire
